// File: hw/rtl/bbte_pkg.sv
// Shared types and constants for the bisection text entry block.
package bbte_pkg;

  localparam int BufferDepthDef = 19;

  localparam logic [4:0] AlphaEmpty  = 5'd27;
  localparam logic [4:0] AlphaNormal = 5'd28;
  localparam logic [4:0] AlphaFull   = 5'd2;
  localparam logic [4:0] IdxSpace    = 5'd26;
  localparam logic [4:0] NumLetters  = 5'd26;

  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [1:0] EvNone   = 2'd0;
  localparam logic [1:0] EvAppend = 2'd1;
  localparam logic [1:0] EvErase  = 2'd2;

  localparam logic KindChoice = 1'b0;
  localparam logic KindRead   = 1'b1;
  localparam logic SideLeft   = 1'b0;

  typedef struct packed {
    logic       kind;
    logic       side;
    logic [4:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] committed_char;
    logic [4:0] typed_length;
    logic [4:0] window_start;
    logic [4:0] window_count;
    logic [7:0] read_char;
  } out_res_t;

endpackage

// File: hw/rtl/binary_bisection_text_entry_top.sv
// Bisection text entry: window update, commit logic and typed buffer.
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register is refilled in the
// same cycle that its result is taken, so only a stalled output stops input.
// Reset clears the typed length and sets the window to the empty alphabet;
// the typed buffer itself is not cleared and holds nothing until written.
module binary_bisection_text_entry_top #(
  parameter int BUFFER_DEPTH = bbte_pkg::BufferDepthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbte_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbte_pkg::out_res_t out_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [4:0] Depth = 5'(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  logic [4:0] typed_count_r, typed_count_nxt;
  logic [4:0] window_base_r, window_base_nxt;
  logic [4:0] window_size_r, window_size_nxt;
  logic       out_valid_r;
  logic [1:0] event_r, event_nxt;
  logic [7:0] cchar_r, cchar_nxt;
  logic [7:0] rchar_r;
  logic       wr_en;
  logic       accept;
  logic       rd_in_range;
  logic [4:0] size_step, base_step, left_half;
  logic [7:0] ch;
  logic       is_erase;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign rd_in_range = in_data.read_index < Depth;

  always_comb begin
    typed_count_nxt = typed_count_r;
    window_base_nxt = window_base_r;
    window_size_nxt = window_size_r;
    event_nxt = bbte_pkg::EvNone;
    cchar_nxt = 8'd0;
    wr_en = 1'b0;
    ch = 8'd0;
    is_erase = 1'b0;
    left_half = 5'((6'(window_size_r) + 6'd1) >> 1);
    size_step = window_size_r;
    base_step = window_base_r;
    if (window_size_r > 5'd1) begin
      if (in_data.side == bbte_pkg::SideLeft) begin
        size_step = left_half;
      end else begin
        base_step = window_base_r + left_half;
        size_step = window_size_r >> 1;
      end
    end
    if (in_data.kind == bbte_pkg::KindChoice) begin
      window_base_nxt = base_step;
      window_size_nxt = size_step;
      if (size_step <= 5'd1) begin
        if (typed_count_r >= Depth) begin
          is_erase = 1'b1;
        end else if (base_step < bbte_pkg::NumLetters) begin
          ch = bbte_pkg::CharA + 8'(base_step);
        end else if (base_step == bbte_pkg::IdxSpace) begin
          ch = bbte_pkg::CharSpace;
        end else begin
          is_erase = 1'b1;
        end
        if (is_erase) begin
          if (typed_count_r > 5'd0) begin
            typed_count_nxt = typed_count_r - 5'd1;
            event_nxt = bbte_pkg::EvErase;
          end
        end else if (typed_count_r < Depth) begin
          wr_en = 1'b1;
          typed_count_nxt = typed_count_r + 5'd1;
          event_nxt = bbte_pkg::EvAppend;
          cchar_nxt = ch;
        end
        window_base_nxt = 5'd0;
        if (typed_count_nxt == 5'd0) begin
          window_size_nxt = bbte_pkg::AlphaEmpty;
        end else if (typed_count_nxt >= Depth) begin
          window_size_nxt = bbte_pkg::AlphaFull;
        end else begin
          window_size_nxt = bbte_pkg::AlphaNormal;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      typed_count_r <= 5'd0;
      window_base_r <= 5'd0;
      window_size_r <= bbte_pkg::AlphaEmpty;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        typed_count_r <= typed_count_nxt;
        window_base_r <= window_base_nxt;
        window_size_r <= window_size_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_r <= event_nxt;
      cchar_r <= cchar_nxt;
    end
  end

  // Typed buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[typed_count_r[AW-1:0]] <= cchar_nxt;
    end
    if (accept) begin
      if (in_data.kind == bbte_pkg::KindRead && rd_in_range) begin
        rchar_r <= mem[in_data.read_index[AW-1:0]];
      end else begin
        rchar_r <= 8'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = '{event_res:      event_r,
                      committed_char: cchar_r,
                      typed_length:   typed_count_r,
                      window_start:   window_base_r,
                      window_count:   window_size_r,
                      read_char:      rchar_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    typed_count_r <= Depth)
    else $error("typed length beyond buffer depth");

  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    window_size_r > 5'd1 && window_size_r <= bbte_pkg::AlphaNormal)
    else $error("window size out of range");

  a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
    6'(window_base_r) + 6'(window_size_r) <= 6'(bbte_pkg::AlphaNormal))
    else $error("window extends past alphabet");

  a_append_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && event_r == bbte_pkg::EvAppend |-> cchar_r != 8'd0)
    else $error("append without character");

  a_erase_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept && event_nxt == bbte_pkg::EvErase |=> typed_count_r == $past(typed_count_r) - 5'd1)
    else $error("erase did not shorten buffer");

endmodule

// File: tb/sv/binary_bisection_text_entry_top_tb.sv
// Self-checking testbench for the bisection text entry block with random idling on both sides.
`timescale 1ns / 100ps

module binary_bisection_text_entry_top_tb;

  localparam int BufDepth = bbte_pkg::BufferDepthDef;
  localparam int EraseIdx = bbte_pkg::AlphaNormal - 1;

  typedef struct packed {
    logic [BufDepth-1:0][7:0] chars;
    int len;
    int base;
    int size;
    int hiwater;
  } entry_st_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bbte_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bbte_pkg::out_res_t out_data;

  bbte_pkg::in_req_t  keys_q[$];
  bbte_pkg::out_res_t echo_q[$];
  bbte_pkg::out_res_t want_res;
  entry_st_t plan_st;
  entry_st_t seen_st;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int erase_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_reads = 0;
  int n_appends = 0;
  int n_erases = 0;
  int n_fills = 0;
  int n_errors = 0;

  binary_bisection_text_entry_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // Advances the text entry state by one request and returns its echo.
  function automatic bbte_pkg::out_res_t bisect_step(inout entry_st_t st,
                                                     input bbte_pkg::in_req_t rq);
    bbte_pkg::out_res_t res;
    int                 left;
    logic [7:0]         ch;
    res = '0;
    if (rq.kind == bbte_pkg::KindRead) begin
      if (rq.read_index < BufDepth) res.read_char = st.chars[rq.read_index];
    end else begin
      if (st.size > 1) begin
        left = (st.size + 1) / 2;
        if (rq.side == bbte_pkg::SideLeft) begin
          st.size = left;
        end else begin
          st.base += left;
          st.size /= 2;
        end
      end
      if (st.size <= 1) begin
        ch = (st.base < bbte_pkg::NumLetters) ? bbte_pkg::CharA + 8'(st.base)
                                              : bbte_pkg::CharSpace;
        if (st.len >= BufDepth || st.base > bbte_pkg::IdxSpace) begin
          if (st.len > 0) begin
            st.len--;
            res.event_res = bbte_pkg::EvErase;
          end
        end else begin
          st.chars[st.len] = ch;
          st.len++;
          if (st.len > st.hiwater) st.hiwater = st.len;
          res.event_res = bbte_pkg::EvAppend;
          res.committed_char = ch;
        end
        st.base = 0;
        st.size = (st.len == 0) ? bbte_pkg::AlphaEmpty :
                  (st.len >= BufDepth) ? bbte_pkg::AlphaFull : bbte_pkg::AlphaNormal;
      end
    end
    res.typed_length = 5'(st.len);
    res.window_start = 5'(st.base);
    res.window_count = 5'(st.size);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_key(input logic kind, input logic side, input logic [4:0] idx);
    bbte_pkg::in_req_t rq;
    rq.kind = kind;
    rq.side = side;
    rq.read_index = idx;
    keys_q.push_back(rq);
    void'(bisect_step(plan_st, rq));
    n_queued++;
  endtask

  // Issues the choices that narrow the planned window down to one entry.
  task automatic steer_to(input int tgt);
    int b;
    int n;
    int left;
    b = plan_st.base;
    n = plan_st.size;
    while (n > 1) begin
      left = (n + 1) / 2;
      if (tgt >= b + left) begin
        push_key(bbte_pkg::KindChoice, !bbte_pkg::SideLeft, 5'($urandom_range(31, 0)));
        b += left;
        n /= 2;
      end else begin
        push_key(bbte_pkg::KindChoice, bbte_pkg::SideLeft, 5'($urandom_range(31, 0)));
        n = left;
      end
    end
  endtask

  task automatic type_one();
    int lo;
    int hi;
    int tgt;
    lo = plan_st.base;
    hi = plan_st.base + plan_st.size - 1;
    if (hi == EraseIdx && $urandom_range(99) < erase_pct) begin
      tgt = EraseIdx;
    end else begin
      if (hi == EraseIdx && lo < hi) hi--;
      if (lo <= bbte_pkg::IdxSpace && hi >= bbte_pkg::IdxSpace && $urandom_range(7) == 0)
        tgt = bbte_pkg::IdxSpace;
      else tgt = $urandom_range(hi, lo);
    end
    steer_to(tgt);
  endtask

  task automatic peek_char();
    int idx;
    if (plan_st.hiwater > 0 && $urandom_range(9) < 7) idx = $urandom_range(plan_st.hiwater - 1, 0);
    else idx = $urandom_range(31, BufDepth);
    push_key(bbte_pkg::KindRead, 1'($urandom_range(1, 0)), 5'(idx));
  endtask

  task automatic random_phase(input int n, input int erase_hi);
    int stop;
    int pick;
    stop = n_queued + n;
    erase_pct = $urandom_range(erase_hi, 0);
    while (n_queued < stop) begin
      if ($urandom_range(15) == 0) erase_pct = $urandom_range(erase_hi, 0);
      pick = $urandom_range(99);
      if (pick < 20) begin
        peek_char();
      end else if (pick < 30) begin
        repeat ($urandom_range(3, 1))
          push_key(bbte_pkg::KindChoice, 1'($urandom_range(1, 0)), 5'($urandom_range(31, 0)));
      end else begin
        type_one();
      end
    end
  endtask

  task automatic drain();
    while (keys_q.size() != 0 || in_valid || echo_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        echo_q.push_back(bisect_step(seen_st, in_data));
        n_accepted++;
        if (in_data.kind == bbte_pkg::KindRead) n_reads++;
      end
      if (!in_valid || !in_stall) begin
        if (keys_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= keys_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (echo_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want_res = echo_q.pop_front();
          check_field("event_res", out_data.event_res, want_res.event_res);
          check_field("committed_char", out_data.committed_char, want_res.committed_char);
          check_field("typed_length", out_data.typed_length, want_res.typed_length);
          check_field("window_start", out_data.window_start, want_res.window_start);
          check_field("window_count", out_data.window_count, want_res.window_count);
          check_field("read_char", out_data.read_char, want_res.read_char);
          if (want_res.event_res == bbte_pkg::EvAppend) n_appends++;
          if (want_res.event_res == bbte_pkg::EvErase) n_erases++;
          if (want_res.event_res == bbte_pkg::EvAppend && want_res.typed_length == BufDepth)
            n_fills++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    plan_st = '{chars: '0, len: 0, base: 0, size: bbte_pkg::AlphaEmpty, hiwater: 0};
    seen_st = plan_st;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // letter, space, reads at the index extremes, last letter, erase, read past the typed length
    steer_to(0);
    steer_to(bbte_pkg::IdxSpace);
    push_key(bbte_pkg::KindRead, bbte_pkg::SideLeft, 5'd0);
    push_key(bbte_pkg::KindRead, !bbte_pkg::SideLeft, 5'd1);
    push_key(bbte_pkg::KindRead, bbte_pkg::SideLeft, 5'd31);
    push_key(bbte_pkg::KindRead, !bbte_pkg::SideLeft, 5'(BufDepth));
    steer_to(bbte_pkg::NumLetters - 1);
    steer_to(EraseIdx);
    push_key(bbte_pkg::KindRead, !bbte_pkg::SideLeft, 5'd2);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 48;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 48;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      random_phase(132, (ph == 0) ? 0 : 60);
      drain();
    end

    repeat (8) @(posedge clk);
    if (echo_q.size() != 0) report_mismatch("results still outstanding at end of run");
    $display("%0d requests checked: %0d reads, %0d characters appended, %0d erased",
             n_accepted, n_reads, n_appends, n_erases);
    $display("buffer filled to %0d characters %0d times", BufDepth, n_fills);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
